@@ hw/rtl/ctsc_pkg.sv @@
package ctsc_pkg;

   localparam int COUNT_BITS_DEFAULT = 16;
   localparam int CAL_RUNS_DEFAULT   = 11;

   localparam int FRAC_BITS        = 10;
   localparam int TICK_BITS        = 16;
   localparam int TIMER_BITS       = 20;
   localparam int SCALE_BITS       = 11;
   localparam int CYCLE_COUNT_BITS = 16;
   localparam int MARGIN_BITS      = 27;
   localparam int OUT_STAGES       = 3;

   localparam logic [SCALE_BITS-1:0] SCALE_ONE = 11'd1024;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 20;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHARGE_TICKS    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TRANSFER_TICKS  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DISCHARGE_TICKS = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_THRESHOLD_SCALE = 2'd3;

   localparam logic [TICK_BITS-1:0]  CHARGE_TICKS_RESET    = 16'd100;
   localparam logic [TICK_BITS-1:0]  TRANSFER_TICKS_RESET  = 16'd100;
   localparam logic [TIMER_BITS-1:0] DISCHARGE_TICKS_RESET = 20'd50000;
   localparam logic [SCALE_BITS-1:0] THRESHOLD_SCALE_RESET = 11'd993;

   typedef struct packed {
      logic drive_enable;
      logic drive_level;
      logic ref_enable;
      logic measurement_valid;
      logic touched;
      logic just_pressed;
      logic calibrated;
   } step_flags_type;

endpackage

@@ hw/rtl/ctsc_sequencer.sv @@
module ctsc_sequencer #(
   parameter int COUNT_BITS = ctsc_pkg::COUNT_BITS_DEFAULT,
   parameter int CAL_RUNS   = ctsc_pkg::CAL_RUNS_DEFAULT
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          accept,
   input  logic                                          sense_level,
   input  logic [ctsc_pkg::TICK_BITS-1:0]                charge_ticks,
   input  logic [ctsc_pkg::TICK_BITS-1:0]                transfer_ticks,
   input  logic [ctsc_pkg::TIMER_BITS-1:0]               discharge_ticks,
   input  logic [COUNT_BITS+ctsc_pkg::FRAC_BITS-1:0]     threshold,
   output ctsc_pkg::step_flags_type                      flags,
   output logic [COUNT_BITS-1:0]                         count,
   output logic [COUNT_BITS+$clog2(CAL_RUNS)-1:0]        cal_sum,
   output logic                                          cal_start
);
   import ctsc_pkg::*;

   localparam int SUM_BITS = COUNT_BITS + $clog2(CAL_RUNS);
   localparam int RUN_BITS = $clog2(CAL_RUNS + 1);
   localparam int THR_BITS = COUNT_BITS + FRAC_BITS;

   localparam logic [1:0] PH_CHARGE    = 2'd0;
   localparam logic [1:0] PH_TRANSFER  = 2'd1;
   localparam logic [1:0] PH_DISCHARGE = 2'd2;

   logic [1:0]            phase_ff, phase_in;
   logic [TIMER_BITS-1:0] timer_ff, timer_in;
   logic [COUNT_BITS-1:0] counter_ff, counter_in;
   logic [SUM_BITS-1:0]   sum_ff, sum_in;
   logic [RUN_BITS-1:0]   runs_ff, runs_in;
   logic                  cal_ff, cal_in;
   logic                  pressed_ff, pressed_in;
   logic                  cal_start_ff, cal_start_in;

   logic [TIMER_BITS:0]   timer_wide;
   logic [THR_BITS-1:0]   fixed;

   assign timer_wide = {1'b0, timer_ff} + (TIMER_BITS+1)'(1);
   assign fixed      = {counter_ff, FRAC_BITS'(0)};

   always_comb begin
      phase_in     = phase_ff;
      timer_in     = timer_wide[TIMER_BITS-1:0];
      counter_in   = counter_ff;
      sum_in       = sum_ff;
      runs_in      = runs_ff;
      cal_in       = cal_ff;
      pressed_in   = pressed_ff;
      cal_start_in = 1'b0;
      flags        = '0;
      count        = '0;
      case (phase_ff)
         PH_CHARGE: begin
            flags.drive_enable = 1'b1;
            flags.drive_level  = 1'b1;
            if (timer_wide >= (TIMER_BITS+1)'(charge_ticks)) begin
               if (counter_ff != '1) begin
                  counter_in = counter_ff + COUNT_BITS'(1);
               end
               phase_in = PH_TRANSFER;
               timer_in = '0;
            end
         end
         PH_TRANSFER: begin
            flags.ref_enable = 1'b1;
            if (timer_wide >= (TIMER_BITS+1)'(transfer_ticks)) begin
               timer_in = '0;
               if (sense_level) begin
                  flags.measurement_valid = 1'b1;
                  count = counter_ff;
                  if (cal_ff) begin
                     pressed_in         = threshold > fixed;
                     flags.just_pressed = (threshold > fixed) && !pressed_ff;
                  end else begin
                     sum_in  = sum_ff + SUM_BITS'(counter_ff);
                     runs_in = runs_ff + RUN_BITS'(1);
                     if (runs_ff == RUN_BITS'(CAL_RUNS - 1)) begin
                        cal_in       = 1'b1;
                        cal_start_in = 1'b1;
                     end
                  end
                  counter_in = '0;
                  phase_in   = PH_DISCHARGE;
               end else begin
                  phase_in = PH_CHARGE;
               end
            end
         end
         default: begin
            flags.drive_enable = 1'b1;
            flags.ref_enable   = 1'b1;
            if (timer_wide >= (TIMER_BITS+1)'(discharge_ticks)) begin
               phase_in = PH_CHARGE;
               timer_in = '0;
            end
         end
      endcase
      flags.touched    = pressed_in;
      flags.calibrated = cal_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_DISCHARGE;
         timer_ff     <= '0;
         counter_ff   <= '0;
         sum_ff       <= '0;
         runs_ff      <= '0;
         cal_ff       <= 1'b0;
         pressed_ff   <= 1'b0;
         cal_start_ff <= 1'b0;
      end else begin
         cal_start_ff <= accept && cal_start_in;
         if (accept) begin
            phase_ff   <= phase_in;
            timer_ff   <= timer_in;
            counter_ff <= counter_in;
            sum_ff     <= sum_in;
            runs_ff    <= runs_in;
            cal_ff     <= cal_in;
            pressed_ff <= pressed_in;
         end
      end
   end

   assign cal_sum   = sum_ff;
   assign cal_start = cal_start_ff;

endmodule

@@ hw/rtl/ctsc_threshold.sv @@
module ctsc_threshold #(
   parameter int COUNT_BITS = ctsc_pkg::COUNT_BITS_DEFAULT,
   parameter int CAL_RUNS   = ctsc_pkg::CAL_RUNS_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   input  logic [COUNT_BITS+$clog2(CAL_RUNS)-1:0]    cal_sum,
   input  logic [ctsc_pkg::SCALE_BITS-1:0]           scale,
   output logic [COUNT_BITS+ctsc_pkg::FRAC_BITS-1:0] threshold
);
   import ctsc_pkg::*;

   localparam int SUM_BITS  = COUNT_BITS + $clog2(CAL_RUNS);
   localparam int THR_BITS  = COUNT_BITS + FRAC_BITS;
   localparam int DIV_SHIFT = SUM_BITS + $clog2(CAL_RUNS);
   localparam int PROD_BITS = 2 * SUM_BITS + 1;
   localparam longint unsigned RECIP_WIDE =
      ((64'd1 << DIV_SHIFT) + 64'(CAL_RUNS) - 64'd1) / 64'(CAL_RUNS);
   localparam logic [SUM_BITS:0] RECIP = (SUM_BITS+1)'(RECIP_WIDE);

   logic [PROD_BITS-1:0]  product;
   logic [COUNT_BITS-1:0] mean_ff;
   logic                  mean_go_ff;
   logic [THR_BITS-1:0]   thr_ff;
   logic [SCALE_BITS-1:0] scale_clamped;
   logic [THR_BITS:0]     scaled;

   assign product       = PROD_BITS'(cal_sum) * PROD_BITS'(RECIP);
   assign scale_clamped = (scale > SCALE_ONE) ? SCALE_ONE : scale;
   assign scaled        = (THR_BITS+1)'(mean_ff) * (THR_BITS+1)'(scale_clamped);

   always_ff @(posedge clock) begin
      if (start) begin
         mean_ff <= product[DIV_SHIFT +: COUNT_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_go_ff <= 1'b0;
         thr_ff     <= '0;
      end else begin
         mean_go_ff <= start;
         if (mean_go_ff) begin
            thr_ff <= scaled[THR_BITS-1:0];
         end
      end
   end

   assign threshold = thr_ff;

endmodule

@@ hw/rtl/ctsc_out_pipe.sv @@
module ctsc_out_pipe #(
   parameter int COUNT_BITS = ctsc_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          in_valid,
   output logic                                          in_ready,
   input  ctsc_pkg::step_flags_type                      in_flags,
   input  logic [COUNT_BITS-1:0]                         in_count,
   input  logic [COUNT_BITS+ctsc_pkg::FRAC_BITS-1:0]     threshold,
   output logic                                          out_valid,
   input  logic                                          out_ready,
   output logic                                          out_drive_enable,
   output logic                                          out_drive_level,
   output logic                                          out_ref_enable,
   output logic                                          out_measurement_valid,
   output logic [ctsc_pkg::CYCLE_COUNT_BITS-1:0]         out_cycle_count,
   output logic signed [ctsc_pkg::MARGIN_BITS-1:0]       out_margin,
   output logic                                          out_touched,
   output logic                                          out_just_pressed,
   output logic                                          out_calibrated
);
   import ctsc_pkg::*;

   localparam int STAGES   = OUT_STAGES;
   localparam int THR_BITS = COUNT_BITS + FRAC_BITS;
   localparam int DIFF_BITS = (THR_BITS + 1 > MARGIN_BITS) ? THR_BITS + 1 : MARGIN_BITS;

   logic [STAGES-1:0]     valid_ff;
   logic [STAGES-1:0]     valid_src;
   logic [STAGES:0]       ready;
   step_flags_type        flags_ff  [STAGES];
   step_flags_type        flags_src [STAGES];
   logic [COUNT_BITS-1:0] count_ff  [STAGES];
   logic [COUNT_BITS-1:0] count_src [STAGES];
   logic [THR_BITS-1:0]   fixed;
   logic [DIFF_BITS-1:0]  diff;

   always_comb begin
      ready[STAGES] = out_ready;
      for (int i = STAGES - 1; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
   end

   always_comb begin
      valid_src[0] = in_valid;
      flags_src[0] = in_flags;
      count_src[0] = in_count;
      for (int i = 1; i < STAGES; i++) begin
         valid_src[i] = valid_ff[i-1];
         flags_src[i] = flags_ff[i-1];
         count_src[i] = count_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < STAGES; i++) begin
            if (ready[i]) begin
               valid_ff[i] <= valid_src[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < STAGES; i++) begin
         if (ready[i] && valid_src[i]) begin
            flags_ff[i] <= flags_src[i];
            count_ff[i] <= count_src[i];
         end
      end
   end

   assign in_ready = ready[0];

   assign fixed = {count_ff[STAGES-1], FRAC_BITS'(0)};
   assign diff  = DIFF_BITS'(fixed)
                - (flags_ff[STAGES-1].calibrated ? DIFF_BITS'(threshold) : '0);

   assign out_valid             = valid_ff[STAGES-1];
   assign out_drive_enable      = flags_ff[STAGES-1].drive_enable;
   assign out_drive_level       = flags_ff[STAGES-1].drive_level;
   assign out_ref_enable        = flags_ff[STAGES-1].ref_enable;
   assign out_measurement_valid = flags_ff[STAGES-1].measurement_valid;
   assign out_cycle_count       = CYCLE_COUNT_BITS'(count_ff[STAGES-1]);
   assign out_margin            = flags_ff[STAGES-1].measurement_valid
                                ? $signed(diff[MARGIN_BITS-1:0]) : '0;
   assign out_touched           = flags_ff[STAGES-1].touched;
   assign out_just_pressed      = flags_ff[STAGES-1].just_pressed;
   assign out_calibrated        = flags_ff[STAGES-1].calibrated;

endmodule

@@ hw/rtl/capacitive_touch_sense_controller.sv @@
// A request moves through the result pipeline, 3 registered stages, to its response.
// Throughput: one request per cycle, while rsp_ready does not stall a full pipeline.
// The threshold is formed after the last calibration measurement, through the calibration
// start, mean (reciprocal multiply) and threshold (scale multiply) registers.
// Reset (synchronous, active high) restores the register defaults, clears calibration
// and starts a full discharge phase.
module capacitive_touch_sense_controller #(
   parameter int COUNT_BITS = ctsc_pkg::COUNT_BITS_DEFAULT,
   parameter int CAL_RUNS   = ctsc_pkg::CAL_RUNS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_sense_level,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic                                    rsp_drive_enable,
   output logic                                    rsp_drive_level,
   output logic                                    rsp_ref_enable,
   output logic                                    rsp_ref_level,
   output logic                                    rsp_measurement_valid,
   output logic [ctsc_pkg::CYCLE_COUNT_BITS-1:0]   rsp_cycle_count,
   output logic signed [ctsc_pkg::MARGIN_BITS-1:0] rsp_margin,
   output logic                                    rsp_touched,
   output logic                                    rsp_just_pressed,
   output logic                                    rsp_calibrated,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [ctsc_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [ctsc_pkg::CSR_DATA_BITS-1:0]      csr_data
);
   import ctsc_pkg::*;

   localparam int SUM_BITS = COUNT_BITS + $clog2(CAL_RUNS);
   localparam int THR_BITS = COUNT_BITS + FRAC_BITS;

   logic [TICK_BITS-1:0]  charge_ticks_ff;
   logic [TICK_BITS-1:0]  transfer_ticks_ff;
   logic [TIMER_BITS-1:0] discharge_ticks_ff;
   logic [SCALE_BITS-1:0] threshold_scale_ff;

   logic                  accept;
   step_flags_type        step_flags;
   logic [COUNT_BITS-1:0] step_count;
   logic [SUM_BITS-1:0]   cal_sum;
   logic                  cal_start;
   logic [THR_BITS-1:0]   threshold;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         charge_ticks_ff    <= CHARGE_TICKS_RESET;
         transfer_ticks_ff  <= TRANSFER_TICKS_RESET;
         discharge_ticks_ff <= DISCHARGE_TICKS_RESET;
         threshold_scale_ff <= THRESHOLD_SCALE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CHARGE_TICKS: begin
               charge_ticks_ff <= csr_data[TICK_BITS-1:0];
            end
            CSR_TRANSFER_TICKS: begin
               transfer_ticks_ff <= csr_data[TICK_BITS-1:0];
            end
            CSR_DISCHARGE_TICKS: begin
               discharge_ticks_ff <= csr_data[TIMER_BITS-1:0];
            end
            CSR_THRESHOLD_SCALE: begin
               threshold_scale_ff <= csr_data[SCALE_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign accept = req_valid && req_ready;

   ctsc_sequencer #(
      .COUNT_BITS (COUNT_BITS),
      .CAL_RUNS   (CAL_RUNS)
   ) u_sequencer (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .sense_level     (req_sense_level),
      .charge_ticks    (charge_ticks_ff),
      .transfer_ticks  (transfer_ticks_ff),
      .discharge_ticks (discharge_ticks_ff),
      .threshold       (threshold),
      .flags           (step_flags),
      .count           (step_count),
      .cal_sum         (cal_sum),
      .cal_start       (cal_start)
   );

   ctsc_threshold #(
      .COUNT_BITS (COUNT_BITS),
      .CAL_RUNS   (CAL_RUNS)
   ) u_threshold (
      .clock     (clock),
      .reset     (reset),
      .start     (cal_start),
      .cal_sum   (cal_sum),
      .scale     (threshold_scale_ff),
      .threshold (threshold)
   );

   ctsc_out_pipe #(
      .COUNT_BITS (COUNT_BITS)
   ) u_out_pipe (
      .clock                 (clock),
      .reset                 (reset),
      .in_valid              (req_valid),
      .in_ready              (req_ready),
      .in_flags              (step_flags),
      .in_count              (step_count),
      .threshold             (threshold),
      .out_valid             (rsp_valid),
      .out_ready             (rsp_ready),
      .out_drive_enable      (rsp_drive_enable),
      .out_drive_level       (rsp_drive_level),
      .out_ref_enable        (rsp_ref_enable),
      .out_measurement_valid (rsp_measurement_valid),
      .out_cycle_count       (rsp_cycle_count),
      .out_margin            (rsp_margin),
      .out_touched           (rsp_touched),
      .out_just_pressed      (rsp_just_pressed),
      .out_calibrated        (rsp_calibrated)
   );

   assign rsp_ref_level = 1'b0;

endmodule

@@ tb/capacitive_touch_sense_controller_tb.sv @@
`timescale 1ns / 100ps

module capacitive_touch_sense_controller_tb;
   import ctsc_pkg::*;

   typedef enum logic [1:0] {
      CHARGING     = 2'd0,
      TRANSFERRING = 2'd1,
      DISCHARGING  = 2'd2
   } pin_phase_type;

   typedef struct {
      logic                        drive_enable;
      logic                        drive_level;
      logic                        ref_enable;
      logic                        ref_level;
      logic                        measurement_valid;
      logic [CYCLE_COUNT_BITS-1:0] cycle_count;
      logic [MARGIN_BITS-1:0]      margin;
      logic                        touched;
      logic                        just_pressed;
      logic                        calibrated;
   } sense_step_type;

   localparam longint unsigned COUNT_LIMIT = (64'd1 << COUNT_BITS_DEFAULT) - 64'd1;
   localparam logic [11:0] DIRECTED_ZERO_TICKS = 12'b0111_0100_1101;
   localparam logic [11:0] DIRECTED_SHORT_TICKS = 12'b1010_0010_0000;
   localparam int LONG_HOLD_CYCLES = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_sense_level = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_drive_enable;
   logic rsp_drive_level;
   logic rsp_ref_enable;
   logic rsp_ref_level;
   logic rsp_measurement_valid;
   logic [CYCLE_COUNT_BITS-1:0] rsp_cycle_count;
   logic signed [MARGIN_BITS-1:0] rsp_margin;
   logic rsp_touched;
   logic rsp_just_pressed;
   logic rsp_calibrated;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_CHARGE_TICKS;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   logic [TICK_BITS-1:0]  charge_len;
   logic [TICK_BITS-1:0]  transfer_len;
   logic [TIMER_BITS-1:0] discharge_len;
   logic [SCALE_BITS-1:0] scale_frac;
   pin_phase_type         pin_phase;
   longint unsigned       phase_count;
   longint unsigned       cycles;
   longint unsigned       cal_sum;
   longint unsigned       cal_runs;
   longint unsigned       threshold_fx;
   logic                  is_cal;
   logic                  pressed;

   logic           sense_samples[$];
   sense_step_type step_forecast[$];
   sense_step_type next_step;
   sense_step_type want;

   int   burst_left;
   int   gap_left;
   logic offer_held;
   int   ready_pct;
   int   window_left;
   int   hold_left;
   bit   hold_request = 1'b0;
   bit   hold_taken = 1'b0;

   int failures = 0;
   int ticks_sent = 0;
   int measurements = 0;
   int presses = 0;
   int count_peak = 0;

   capacitive_touch_sense_controller u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_sense_level       (req_sense_level),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_drive_enable      (rsp_drive_enable),
      .rsp_drive_level       (rsp_drive_level),
      .rsp_ref_enable        (rsp_ref_enable),
      .rsp_ref_level         (rsp_ref_level),
      .rsp_measurement_valid (rsp_measurement_valid),
      .rsp_cycle_count       (rsp_cycle_count),
      .rsp_margin            (rsp_margin),
      .rsp_touched           (rsp_touched),
      .rsp_just_pressed      (rsp_just_pressed),
      .rsp_calibrated        (rsp_calibrated),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   task automatic advance_sensor(input logic sense, output sense_step_type step);
      longint unsigned fixed_count;
      longint unsigned scale_used;
      step = '{default: '0};
      case (pin_phase)
         CHARGING: begin
            step.drive_enable = 1'b1;
            step.drive_level  = 1'b1;
            if (phase_count + 64'd1 >= charge_len) begin
               if (cycles < COUNT_LIMIT) cycles++;
               pin_phase   = TRANSFERRING;
               phase_count = 0;
            end else begin
               phase_count++;
            end
         end
         TRANSFERRING: begin
            step.ref_enable = 1'b1;
            if (phase_count + 64'd1 >= transfer_len) begin
               phase_count = 0;
               if (sense) begin
                  fixed_count = cycles << FRAC_BITS;
                  if (is_cal) begin
                     if (threshold_fx > fixed_count) begin
                        step.just_pressed = !pressed;
                        pressed = 1'b1;
                     end else begin
                        pressed = 1'b0;
                     end
                  end else begin
                     cal_sum += cycles;
                     cal_runs++;
                     if (cal_runs >= CAL_RUNS_DEFAULT) begin
                        scale_used = 64'((scale_frac > SCALE_ONE) ? SCALE_ONE : scale_frac);
                        threshold_fx = (cal_sum / CAL_RUNS_DEFAULT) * scale_used;
                        is_cal = 1'b1;
                     end
                  end
                  step.measurement_valid = 1'b1;
                  step.cycle_count = CYCLE_COUNT_BITS'(cycles);
                  step.margin = MARGIN_BITS'(fixed_count - threshold_fx);
                  cycles    = 0;
                  pin_phase = DISCHARGING;
               end else begin
                  pin_phase = CHARGING;
               end
            end else begin
               phase_count++;
            end
         end
         default: begin
            step.drive_enable = 1'b1;
            step.ref_enable   = 1'b1;
            if (phase_count + 64'd1 >= discharge_len) begin
               pin_phase   = CHARGING;
               phase_count = 0;
            end else begin
               phase_count++;
            end
         end
      endcase
      step.touched    = pressed;
      step.calibrated = is_cal;
   endtask

   function automatic void check_field(input string what, input logic [63:0] want_v,
                                       input logic [63:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s expected 0x%0h got 0x%0h", $time, what, want_v, got_v);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = $urandom_range(1, 48);
         gap_left   = 0;
      end else begin
         offer_held = req_valid;
         if (req_valid && req_ready) begin
            advance_sensor(req_sense_level, next_step);
            step_forecast.push_back(next_step);
            ticks_sent++;
            offer_held = 1'b0;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 48);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end
         if (!offer_held) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (sense_samples.size() != 0) begin
               req_valid       <= 1'b1;
               req_sense_level <= sense_samples.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b1;
         ready_pct   = 100;
         window_left = 0;
         hold_left   = 0;
      end else begin
         if (hold_request && !hold_taken) begin
            hold_left  = LONG_HOLD_CYCLES;
            hold_taken = 1'b1;
         end
         if (window_left == 0) begin
            window_left = $urandom_range(16, 128);
            case ($urandom_range(0, 3))
               0, 1: ready_pct = 100;
               2: ready_pct = 75;
               default: ready_pct = 35;
            endcase
         end
         window_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(1, 100) <= ready_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (step_forecast.size() == 0) begin
            $display("%0t: response with no request outstanding", $time);
            failures++;
         end else begin
            want = step_forecast.pop_front();
            check_field("drive_enable", 64'(want.drive_enable), 64'(rsp_drive_enable));
            check_field("drive_level", 64'(want.drive_level), 64'(rsp_drive_level));
            check_field("ref_enable", 64'(want.ref_enable), 64'(rsp_ref_enable));
            check_field("ref_level", 64'(want.ref_level), 64'(rsp_ref_level));
            check_field("measurement_valid", 64'(want.measurement_valid),
                        64'(rsp_measurement_valid));
            check_field("cycle_count", 64'(want.cycle_count), 64'(rsp_cycle_count));
            check_field("margin", 64'(want.margin), 64'(unsigned'(rsp_margin)));
            check_field("touched", 64'(want.touched), 64'(rsp_touched));
            check_field("just_pressed", 64'(want.just_pressed), 64'(rsp_just_pressed));
            check_field("calibrated", 64'(want.calibrated), 64'(rsp_calibrated));
            if (want.measurement_valid) begin
               measurements++;
               if (int'(want.cycle_count) > count_peak) count_peak = int'(want.cycle_count);
            end
            if (want.just_pressed) presses++;
         end
      end
   end

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_CHARGE_TICKS:    charge_len = value[TICK_BITS-1:0];
         CSR_TRANSFER_TICKS:  transfer_len = value[TICK_BITS-1:0];
         CSR_DISCHARGE_TICKS: discharge_len = value[TIMER_BITS-1:0];
         default:             scale_frac = value[SCALE_BITS-1:0];
      endcase
   endtask

   task automatic configure(input logic [CSR_DATA_BITS-1:0] charge,
                            input logic [CSR_DATA_BITS-1:0] transfer,
                            input logic [CSR_DATA_BITS-1:0] discharge,
                            input logic [CSR_DATA_BITS-1:0] scale);
      write_csr(CSR_CHARGE_TICKS, charge);
      write_csr(CSR_TRANSFER_TICKS, transfer);
      write_csr(CSR_DISCHARGE_TICKS, discharge);
      write_csr(CSR_THRESHOLD_SCALE, scale);
   endtask

   task automatic wait_drained();
      while (sense_samples.size() != 0 || req_valid || step_forecast.size() != 0)
         @(negedge clock);
   endtask

   task automatic run_phase(input int count, input int pct_high);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(1, 10) == 1) sense_samples.push_back(1'($urandom_range(0, 1)));
         else sense_samples.push_back($urandom_range(1, 100) <= pct_high);
      end
      wait_drained();
   endtask

   initial begin
      charge_len    = CHARGE_TICKS_RESET;
      transfer_len  = TRANSFER_TICKS_RESET;
      discharge_len = DISCHARGE_TICKS_RESET;
      scale_frac    = THRESHOLD_SCALE_RESET;
      pin_phase     = DISCHARGING;
      phase_count   = 0;
      cycles        = 0;
      cal_sum       = 0;
      cal_runs      = 0;
      threshold_fx  = 0;
      is_cal        = 1'b0;
      pressed       = 1'b0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // cut the power-up discharge short and run with zero-length phases
      configure(0, 0, 0, 2047);
      for (int i = 0; i < 12; i++) sense_samples.push_back(DIRECTED_ZERO_TICKS[i]);
      wait_drained();
      configure(20'hF0001, 2, 1, 2047);
      for (int i = 0; i < 12; i++) sense_samples.push_back(DIRECTED_SHORT_TICKS[i]);
      wait_drained();

      // calibration lands here with the scale clamped
      configure(1, 1, 1, 2047);
      run_phase(260, 25);
      configure(2, 1, 3, 0);
      hold_request = 1'b1;
      run_phase(220, 15);
      configure(3, 2, 1, 512);
      run_phase(220, 30);
      configure(1, 3, 2, 1024);
      run_phase(220, 10);
      configure(65535, 1, 1, 993);
      run_phase(60, 50);
      configure(1, 65535, 1, 1);
      run_phase(60, 50);
      configure(1, 1, 1048575, 1024);
      run_phase(60, 50);
      configure(0, 0, 0, 700);
      run_phase(220, 20);
      configure(4, 4, 5, 100);
      run_phase(220, 35);

      configure(1, 1, 1, 993);
      run_phase(40, 30);

      repeat (3 * OUT_STAGES) @(posedge clock);
      $display("covered %0d ticks, %0d measurements, %0d presses, highest count %0d",
               ticks_sent, measurements, presses, count_peak);
      $display("calibrated %0b, threshold 0x%0h, %0d mismatches", is_cal, threshold_fx,
               failures);
      if (failures == 0) begin
         $display("capacitive_touch_sense_controller regression: pass");
      end else begin
         $display("capacitive_touch_sense_controller regression: fail");
      end
      $finish;
   end

   initial begin
      #60_000_000;
      $display("timeout with %0d responses outstanding", step_forecast.size());
      $display("capacitive_touch_sense_controller regression: fail");
      $finish;
   end

endmodule
